// ===== design/wqid_pkg.sv =====
// Shared constants, codes and types of the work queue instance dispatcher.
`default_nettype none

package wqid_pkg;

    // Queue and pool sizing
    localparam int QUEUE_DEPTH   = 64;
    localparam int MAX_INSTANCES = 16;

    // Field widths fixed by the interface
    localparam int TAG_W      = 16;
    localparam int WANT_W     = 5;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 48;
    localparam int LOAD_W     = 48;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int PENDING_W  = 7;
    localparam int RR_W       = 32;
    localparam int TOTAL_W    = 32;
    localparam int POLICY_W   = 2;
    localparam int POOL_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Derived widths
    localparam int QADDR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W      = QADDR_W + 1;
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int INST_W     = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CNT_W      = $clog2(MAX_INSTANCES + 1);
    localparam int RR_STEP_W  = $clog2(RR_W);
    localparam int STEP_W     = (CNT_W > RR_STEP_W) ? CNT_W : RR_STEP_W;

    // Instance id meaning "none found"
    localparam logic [WANT_W-1:0] INST_NONE = '1;

    // Request codes
    typedef enum logic [1:0] {
        REQ_SUBMIT = 2'd0,
        REQ_ASSIGN = 2'd1,
        REQ_LOAD   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_ASSIGNED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_LOADED   = 3'd5
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL   = 1'd1;

    // Policy codes
    localparam logic [POLICY_W-1:0] POLICY_RR = 2'd0;

    // One queued work item
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [WANT_W-1:0] want;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] etime;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== design/wqid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wqid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/wqid_cmp.sv =====
// Shared compare and subtract unit used by the modulo and least-load walks.
`default_nettype none

module wqid_cmp
    import wqid_pkg::*;
(
    input  wire logic [LOAD_W-1:0] a,
    input  wire logic [LOAD_W-1:0] b,
    output logic                   lt,
    output logic      [LOAD_W-1:0] diff
);

    logic [LOAD_W:0] wide_diff;

    // Subtract once; the borrow is the less-than flag
    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign lt        = wide_diff[LOAD_W];
    assign diff      = wide_diff[LOAD_W-1:0];

endmodule

`default_nettype wire

// ===== design/wqid_load_tbl.sv =====
// Per-instance load table: one write port, one read port, cleared at reset.
`default_nettype none

module wqid_load_tbl
    import wqid_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic [INST_W-1:0] waddr,
    input  wire logic [LOAD_W-1:0] wdata,
    input  wire logic [INST_W-1:0] raddr,
    output logic      [LOAD_W-1:0] rdata
);

    logic [LOAD_W-1:0] load_reg [MAX_INSTANCES];

    // Store reported loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_INSTANCES; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            load_reg[waddr] <= wdata;
        end
    end

    // Read the entry under the walk index
    assign rdata = load_reg[raddr];

endmodule

`default_nettype wire

// ===== design/work_queue_instance_dispatcher.sv =====
// Work queue dispatcher: FIFO of work items, load table and dispatch sequencer.
//
// Usage: items arrive on req_valid/req_ready with req_type selecting submit,
// assign or load report; every item except request type three returns one
// item on rsp_valid/rsp_ready. The user must write the pool size and policy
// through cfg_we/cfg_index/cfg_wdata only while the block is idle; the block
// itself does not enforce this. From accept to result, submit, load report
// and assign on an empty queue go straight to the done state; an assign with
// an explicit instance or a dropped item passes through the pop state first;
// a round-robin assign then runs the cursor modulo one quotient bit per cycle
// through the shared subtractor, and a least-load assign walks the load
// counters, one compared per cycle. The block takes one item at a time:
// req_ready is high only while the sequencer is idle. A finished result sits
// in the output register, so a new item is accepted while the receiver
// stalls; the sequencer then holds its next result until the output register
// frees up.
// Reset clears the queue pointers, load table, counters and configuration;
// queue storage is not cleared and needs no clearing pass.
`default_nettype none

module work_queue_instance_dispatcher
    import wqid_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic        [1:0]            req_type,
    input  wire logic        [TAG_W-1:0]      item_tag,
    input  wire logic signed [WANT_W-1:0]     requested_instance,
    input  wire logic signed [PRIO_W-1:0]     item_priority,
    input  wire logic        [TIME_W-1:0]     enqueue_time,
    input  wire logic        [TIME_W-1:0]     current_time,
    input  wire logic        [SLOT_W-1:0]     load_slot,
    input  wire logic        [LOAD_W-1:0]     load_value,

    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic             [STATUS_W-1:0]   status,
    output logic             [TAG_W-1:0]      out_tag,
    output logic signed      [WANT_W-1:0]     assigned_instance,
    output logic signed      [PRIO_W-1:0]     out_priority,
    output logic             [TIME_W-1:0]     out_enqueue_time,
    output logic             [PENDING_W-1:0]  pending_count,
    output logic             [TOTAL_W-1:0]    assigned_total
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_MOD,
        S_LEAST,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [POLICY_W-1:0] policy_reg, policy_next;
    logic [POOL_W-1:0]   pool_reg, pool_next;

    // Queue pointers and counters
    logic [QADDR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [RR_W-1:0]     rr_reg, rr_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    // Iteration state
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [RR_W-1:0]     sh_reg, sh_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [LOAD_W-1:0]   best_reg, best_next;
    logic                have_reg, have_next;
    logic [INST_W-1:0]   pick_reg, pick_next;

    // Result staging
    status_t             res_status_reg, res_status_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic [WANT_W-1:0]   res_inst_reg, res_inst_next;
    logic [PRIO_W-1:0]   res_prio_reg, res_prio_next;
    logic [TIME_W-1:0]   res_time_reg, res_time_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [WANT_W-1:0]   out_inst_reg, out_inst_next;
    logic [PRIO_W-1:0]   out_prio_reg, out_prio_next;
    logic [TIME_W-1:0]   out_time_reg, out_time_next;
    logic [PENDING_W-1:0] out_pend_reg, out_pend_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;

    // Queue storage
    logic                ram_we, ram_re;
    logic [QADDR_W-1:0]  ram_waddr;
    entry_t              ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0]  ram_rdata_bits;

    // Load table
    logic                tbl_we;
    logic [LOAD_W-1:0]   tbl_rdata;

    // Shared unit
    logic [LOAD_W-1:0]   unit_a, unit_b, unit_diff;
    logic                unit_lt;

    // Derived values
    logic [CNT_W-1:0]    live_n;
    logic [SUM_W-1:0]    tail_sum;
    logic [QADDR_W-1:0]  tail;
    logic [QADDR_W-1:0]  head_inc;
    logic [CNT_W:0]      mod_t;
    logic [CNT_W-1:0]    rem_step;

    wqid_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = entry_t'(ram_rdata_bits);

    wqid_load_tbl u_load_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (INST_W'(load_slot)),
        .wdata (load_value),
        .raddr (INST_W'(cnt_reg)),
        .rdata (tbl_rdata)
    );

    wqid_cmp u_cmp (
        .a    (unit_a),
        .b    (unit_b),
        .lt   (unit_lt),
        .diff (unit_diff)
    );

    // Clamp the pool to the table size
    assign live_n = (32'(pool_reg) > 32'(MAX_INSTANCES)) ? CNT_W'(MAX_INSTANCES)
                                                        : CNT_W'(pool_reg);

    // Tail slot and head advance with wrap
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? QADDR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                      : QADDR_W'(tail_sum);
    assign head_inc = (head_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // One restoring step of the cursor modulo
    assign mod_t    = {rem_reg, sh_reg[RR_W-1]};
    assign rem_step = unit_lt ? CNT_W'(mod_t) : CNT_W'(unit_diff);

    // Feed the shared unit
    always_comb
    begin
        unit_a = '0;
        unit_b = '0;
        case (state_reg)
            S_MOD:
            begin
                unit_a = LOAD_W'(mod_t);
                unit_b = LOAD_W'(live_n);
            end
            S_LEAST:
            begin
                unit_a = tbl_rdata;
                unit_b = best_reg;
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    // Build the entry for a submit
    always_comb
    begin
        ram_wdata.tag   = item_tag;
        ram_wdata.want  = requested_instance;
        ram_wdata.prio  = item_priority;
        ram_wdata.etime = (enqueue_time == '0) ? current_time : enqueue_time;
    end

    assign ram_waddr = tail;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        pool_next       = pool_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        rr_next         = rr_reg;
        total_next      = total_reg;
        cnt_next        = cnt_reg;
        sh_next         = sh_reg;
        rem_next        = rem_reg;
        best_next       = best_reg;
        have_next       = have_reg;
        pick_next       = pick_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_inst_next   = res_inst_reg;
        res_prio_next   = res_prio_reg;
        res_time_next   = res_time_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_inst_next   = out_inst_reg;
        out_prio_next   = out_prio_reg;
        out_time_next   = out_time_reg;
        out_pend_next   = out_pend_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        tbl_we          = 1'b0;

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_next = cfg_wdata[POLICY_W-1:0];
                CFG_POOL:   pool_next   = cfg_wdata[POOL_W-1:0];
            endcase
        end

        // Drop the output item once taken
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_tag_next  = '0;
                    res_inst_next = INST_NONE;
                    res_prio_next = '0;
                    res_time_next = '0;
                    unique case (req_t'(req_type))
                        REQ_SUBMIT:
                        begin
                            if (fill_reg == FILL_W'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                fill_next       = fill_reg + 1'b1;
                                res_status_next = ST_QUEUED;
                            end
                            state_next = S_DONE;
                        end
                        REQ_LOAD:
                        begin
                            tbl_we          = (32'(load_slot) < 32'(MAX_INSTANCES));
                            res_status_next = ST_LOADED;
                            state_next      = S_DONE;
                        end
                        REQ_ASSIGN:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                head_next  = head_inc;
                                fill_next  = fill_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        REQ_NONE:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                // Latch the popped item and pick a path
                res_tag_next  = ram_rdata.tag;
                res_prio_next = ram_rdata.prio;
                res_time_next = ram_rdata.etime;
                cnt_next      = '0;
                if (!ram_rdata.want[WANT_W-1])
                begin
                    res_inst_next   = (32'(ram_rdata.want) < 32'(live_n))
                                      ? ram_rdata.want : INST_NONE;
                    res_status_next = ST_ASSIGNED;
                    total_next      = total_reg + 1'b1;
                    state_next      = S_DONE;
                end
                else if (policy_reg == POLICY_RR)
                begin
                    if (live_n == '0)
                    begin
                        res_inst_next   = INST_NONE;
                        res_status_next = ST_DROPPED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        sh_next    = rr_reg;
                        rem_next   = '0;
                        state_next = S_MOD;
                    end
                end
                else
                begin
                    have_next  = 1'b0;
                    best_next  = '0;
                    pick_next  = '0;
                    state_next = S_LEAST;
                end
            end

            S_MOD:
            begin
                // One quotient bit per cycle
                rem_next = rem_step;
                sh_next  = {sh_reg[RR_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(RR_W - 1))
                begin
                    res_inst_next   = WANT_W'(rem_step);
                    res_status_next = ST_ASSIGNED;
                    rr_next         = rr_reg + 1'b1;
                    total_next      = total_reg + 1'b1;
                    state_next      = S_DONE;
                end
            end

            S_LEAST:
            begin
                // Walk the load counters, keep the first minimum
                if (cnt_reg == STEP_W'(live_n))
                begin
                    res_inst_next   = have_reg ? WANT_W'(pick_reg) : INST_NONE;
                    res_status_next = ST_ASSIGNED;
                    total_next      = total_reg + 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (!have_reg || unit_lt)
                    begin
                        best_next = tbl_rdata;
                        pick_next = INST_W'(cnt_reg);
                        have_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register when it frees up
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tag_next    = res_tag_reg;
                    out_inst_next   = res_inst_reg;
                    out_prio_next   = res_prio_reg;
                    out_time_next   = res_time_reg;
                    out_pend_next   = PENDING_W'(fill_reg);
                    out_total_next  = total_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= '0;
            pool_reg       <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            rr_reg         <= '0;
            total_reg      <= '0;
            cnt_reg        <= '0;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            pool_reg       <= pool_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            rr_reg         <= rr_next;
            total_reg      <= total_next;
            cnt_reg        <= cnt_next;
            have_reg       <= have_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sh_reg         <= sh_next;
        rem_reg        <= rem_next;
        best_reg       <= best_next;
        pick_reg       <= pick_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_inst_reg   <= res_inst_next;
        res_prio_reg   <= res_prio_next;
        res_time_reg   <= res_time_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_inst_reg   <= out_inst_next;
        out_prio_reg   <= out_prio_next;
        out_time_reg   <= out_time_next;
        out_pend_reg   <= out_pend_next;
        out_total_reg  <= out_total_next;
    end

    // Ports
    assign req_ready         = (state_reg == S_IDLE);
    assign rsp_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign out_tag           = out_tag_reg;
    assign assigned_instance = out_inst_reg;
    assign out_priority      = out_prio_reg;
    assign out_enqueue_time  = out_time_reg;
    assign pending_count     = out_pend_reg;
    assign assigned_total    = out_total_reg;

endmodule

`default_nettype wire
